// File: design/sgev_pkg.sv
// ----------------------------------------------------------------------------
// Segment eviction table package
// Shared sizes, command and result codes, entry layout and state type.
// ----------------------------------------------------------------------------
package sgev_pkg;

  localparam int CAPACITY   = 64;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int CNT_BITS   = $clog2(CAPACITY + 1);
  localparam int COORD_BITS = 16;
  localparam int ID_BITS    = 16;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REPORT = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] KIND_EVICT    = 3'd0;
  localparam logic [2:0] KIND_SURVIVOR = 3'd1;
  localparam logic [2:0] KIND_NONE     = 3'd2;
  localparam logic [2:0] KIND_OVERFLOW = 3'd3;
  localparam logic [2:0] KIND_CLEARED  = 3'd4;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] sx;
    logic signed [COORD_BITS-1:0] sy;
    logic signed [COORD_BITS-1:0] ex;
    logic signed [COORD_BITS-1:0] ey;
  } seg_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    seg_t               seg;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_MUL,
    ST_SCAN_DEC,
    ST_APPEND,
    ST_REPORT,
    ST_EMIT_ONE
  } state_t;

endpackage

// File: design/top_segment_eviction_table_top.sv
// ----------------------------------------------------------------------------
// Segment eviction table
// Keeps an ordered table of up to 64 segments in one RAM. An add command
// removes every stored segment that the new one touches (proper crossing or
// collinear endpoint inside the other's bounding box), reports each removed id
// in table order, compacts the table and appends the new segment under the
// next id; when the table is still full the new segment is refused with an
// overflow result. A report command lists the surviving ids in order, and a
// clear command empties the table and restarts ids at 1. One command is worked
// at a time. In an add each stored entry passes through the RAM read, a
// cross-product register stage and a decision step that also writes the
// compacted entry back; a report does one RAM read per survivor. A result
// register sits on the output, so a new command is taken while the last
// result still waits. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module top_segment_eviction_table_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_cmd,
  input  logic signed [sgev_pkg::COORD_BITS-1:0] in_start_x,
  input  logic signed [sgev_pkg::COORD_BITS-1:0] in_start_y,
  input  logic signed [sgev_pkg::COORD_BITS-1:0] in_end_x,
  input  logic signed [sgev_pkg::COORD_BITS-1:0] in_end_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sgev_pkg::ID_BITS-1:0]         out_stick_id,
  output logic [2:0]                           out_kind,
  output logic                                 out_last
);
  import sgev_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_BITS-1:0]  live_r, live_nxt;
  logic [ID_BITS-1:0]   next_id_r, next_id_nxt;
  logic [CNT_BITS-1:0]  idx_r, idx_nxt;
  logic [CNT_BITS-1:0]  keep_r, keep_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [ID_BITS-1:0]   pend_id_r, pend_id_nxt;
  seg_t                 new_seg_r, new_seg_nxt;
  logic [2:0]           one_kind_r, one_kind_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ID_BITS-1:0]   out_stick_id_r, out_stick_id_nxt;
  logic [2:0]           out_kind_r, out_kind_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                  in_fire;
  logic                  slot_free;
  logic                  touch;
  logic                  touch_load;
  logic                  dec_go;
  logic                  scan_end;
  logic                  rep_last;
  logic [ID_BITS-1:0]    id_inc;
  logic                  emit;
  logic [ID_BITS-1:0]    emit_id;
  logic [2:0]            emit_kind;
  logic                  emit_last;
  logic                  mem_we;
  logic [ADDR_BITS-1:0]  mem_waddr;
  logic [ENTRY_BITS-1:0] mem_wdata;
  logic [ENTRY_BITS-1:0] rd_data;
  entry_t                rd_entry;
  entry_t                app_entry;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign rd_entry  = entry_t'(rd_data);
  // The RAM reads the index of the next cycle, so its data always matches idx_r.
  assign dec_go    = !(touch && pend_valid_r && !slot_free);
  assign scan_end  = ((idx_r + 1'b1) == live_r);
  assign rep_last  = ((idx_r + 1'b1) == live_r);
  assign id_inc    = (next_id_r + 1'b1 == '0) ? ID_BITS'(1) : next_id_r + 1'b1;

  always_comb begin
    app_entry.id  = next_id_r;
    app_entry.seg = new_seg_r;
  end

  sgev_ram #(
    .WIDTH(ENTRY_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(idx_nxt[ADDR_BITS-1:0]),
    .rdata(rd_data)
  );

  sgev_touch u_touch (
    .clk    (clk),
    .load   (touch_load),
    .new_seg(new_seg_r),
    .cur_seg(rd_entry.seg),
    .touch  (touch)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_ADD:    state_nxt = (live_r == '0) ? ST_APPEND : ST_SCAN_MUL;
            CMD_REPORT: state_nxt = (live_r == '0) ? ST_EMIT_ONE : ST_REPORT;
            default:    state_nxt = ST_EMIT_ONE;
          endcase
        end
      end
      ST_SCAN_MUL: state_nxt = ST_SCAN_DEC;
      ST_SCAN_DEC: begin
        if (dec_go) begin
          state_nxt = scan_end ? ST_APPEND : ST_SCAN_MUL;
        end
      end
      ST_APPEND: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPORT: begin
        if (slot_free && rep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_ONE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    live_nxt       = live_r;
    next_id_nxt    = next_id_r;
    idx_nxt        = idx_r;
    keep_nxt       = keep_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    new_seg_nxt    = new_seg_r;
    one_kind_nxt   = one_kind_r;
    touch_load     = 1'b0;
    emit           = 1'b0;
    emit_id        = '0;
    emit_kind      = KIND_NONE;
    emit_last      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = keep_r[ADDR_BITS-1:0];
    mem_wdata      = rd_data;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          new_seg_nxt.sx = in_start_x;
          new_seg_nxt.sy = in_start_y;
          new_seg_nxt.ex = in_end_x;
          new_seg_nxt.ey = in_end_y;
          idx_nxt        = '0;
          keep_nxt       = '0;
          pend_valid_nxt = 1'b0;
          one_kind_nxt   = KIND_NONE;
          if (in_cmd == CMD_CLEAR) begin
            live_nxt     = '0;
            next_id_nxt  = ID_BITS'(1);
            one_kind_nxt = KIND_CLEARED;
          end
        end
      end
      ST_SCAN_MUL: touch_load = 1'b1;
      ST_SCAN_DEC: begin
        if (dec_go) begin
          idx_nxt = idx_r + 1'b1;
          if (touch) begin
            // Hold each evicted id back one step so the final one can carry last.
            if (pend_valid_r) begin
              emit      = 1'b1;
              emit_id   = pend_id_r;
              emit_kind = KIND_EVICT;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = rd_entry.id;
          end else begin
            mem_we   = (keep_r != idx_r);
            keep_nxt = keep_r + 1'b1;
          end
        end
      end
      ST_APPEND: begin
        if (slot_free) begin
          emit           = 1'b1;
          emit_last      = 1'b1;
          pend_valid_nxt = 1'b0;
          if (keep_r != CNT_BITS'(CAPACITY)) begin
            mem_we      = 1'b1;
            mem_wdata   = app_entry;
            live_nxt    = keep_r + 1'b1;
            next_id_nxt = id_inc;
            if (pend_valid_r) begin
              emit_id   = pend_id_r;
              emit_kind = KIND_EVICT;
            end
          end else begin
            live_nxt  = keep_r;
            emit_kind = KIND_OVERFLOW;
          end
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_id   = rd_entry.id;
          emit_kind = KIND_SURVIVOR;
          emit_last = rep_last;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      ST_EMIT_ONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = one_kind_r;
          emit_last = 1'b1;
        end
      end
      default: ;
    endcase

    out_valid_nxt    = out_valid_r;
    out_stick_id_nxt = out_stick_id_r;
    out_kind_nxt     = out_kind_r;
    out_last_nxt     = out_last_r;
    if (emit) begin
      out_valid_nxt    = 1'b1;
      out_stick_id_nxt = emit_id;
      out_kind_nxt     = emit_kind;
      out_last_nxt     = emit_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      live_r       <= '0;
      next_id_r    <= ID_BITS'(1);
      idx_r        <= '0;
      keep_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      live_r       <= live_nxt;
      next_id_r    <= next_id_nxt;
      idx_r        <= idx_nxt;
      keep_r       <= keep_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r      <= pend_id_nxt;
    new_seg_r      <= new_seg_nxt;
    one_kind_r     <= one_kind_nxt;
    out_stick_id_r <= out_stick_id_nxt;
    out_kind_r     <= out_kind_nxt;
    out_last_r     <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_stick_id = out_stick_id_r;
  assign out_kind     = out_kind_r;
  assign out_last     = out_last_r;

endmodule

// File: design/sgev_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sgev_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/sgev_touch.sv
// ----------------------------------------------------------------------------
// Segment touch test
// Registers the eight cross-product terms of the four orientations, then
// decides from their differences and from bounding-box checks whether the
// new segment touches the stored one.
// ----------------------------------------------------------------------------
module sgev_touch (
  input  logic          clk,
  input  logic          load,
  input  sgev_pkg::seg_t new_seg,
  input  sgev_pkg::seg_t cur_seg,
  output logic          touch
);
  import sgev_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int OW = PW + 1;

  function automatic logic signed [DW-1:0] diff(input logic signed [COORD_BITS-1:0] a,
                                                 input logic signed [COORD_BITS-1:0] b);
    logic signed [DW-1:0] aw;
    logic signed [DW-1:0] bw;
    aw = DW'(a);
    bw = DW'(b);
    return aw - bw;
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [PW-1:0] aw;
    logic signed [PW-1:0] bw;
    aw = PW'(a);
    bw = PW'(b);
    return aw * bw;
  endfunction

  // True when c lies inside the bounding box spanned by a and b.
  function automatic logic in_box(input logic signed [COORD_BITS-1:0] ax,
                                  input logic signed [COORD_BITS-1:0] ay,
                                  input logic signed [COORD_BITS-1:0] bx,
                                  input logic signed [COORD_BITS-1:0] by,
                                  input logic signed [COORD_BITS-1:0] cx,
                                  input logic signed [COORD_BITS-1:0] cy);
    logic okx;
    logic oky;
    okx = (cx >= ax || cx >= bx) && (cx <= ax || cx <= bx);
    oky = (cy >= ay || cy >= by) && (cy <= ay || cy <= by);
    return okx && oky;
  endfunction

  logic signed [DW-1:0] sdx, sdy, ndx, ndy;
  logic signed [PW-1:0] p1a_nxt, p1b_nxt, p2a_nxt, p2b_nxt;
  logic signed [PW-1:0] p3a_nxt, p3b_nxt, p4a_nxt, p4b_nxt;
  logic signed [PW-1:0] p1a_r, p1b_r, p2a_r, p2b_r;
  logic signed [PW-1:0] p3a_r, p3b_r, p4a_r, p4b_r;
  seg_t                 cur_r;
  logic signed [OW-1:0] d1, d2, d3, d4;
  logic                 d1z, d2z, d3z, d4z;
  logic                 cross_a, cross_b;

  // New segment is p1-p2, stored segment is p3-p4.
  always_comb begin
    sdx = diff(cur_seg.ex, cur_seg.sx);
    sdy = diff(cur_seg.ey, cur_seg.sy);
    ndx = diff(new_seg.ex, new_seg.sx);
    ndy = diff(new_seg.ey, new_seg.sy);
    p1a_nxt = mul(diff(new_seg.sx, cur_seg.sx), sdy);
    p1b_nxt = mul(diff(new_seg.sy, cur_seg.sy), sdx);
    p2a_nxt = mul(diff(new_seg.ex, cur_seg.sx), sdy);
    p2b_nxt = mul(diff(new_seg.ey, cur_seg.sy), sdx);
    p3a_nxt = mul(diff(cur_seg.sx, new_seg.sx), ndy);
    p3b_nxt = mul(diff(cur_seg.sy, new_seg.sy), ndx);
    p4a_nxt = mul(diff(cur_seg.ex, new_seg.sx), ndy);
    p4b_nxt = mul(diff(cur_seg.ey, new_seg.sy), ndx);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p1a_r <= p1a_nxt;
      p1b_r <= p1b_nxt;
      p2a_r <= p2a_nxt;
      p2b_r <= p2b_nxt;
      p3a_r <= p3a_nxt;
      p3b_r <= p3b_nxt;
      p4a_r <= p4a_nxt;
      p4b_r <= p4b_nxt;
      cur_r <= cur_seg;
    end
  end

  always_comb begin
    d1 = OW'(p1a_r) - OW'(p1b_r);
    d2 = OW'(p2a_r) - OW'(p2b_r);
    d3 = OW'(p3a_r) - OW'(p3b_r);
    d4 = OW'(p4a_r) - OW'(p4b_r);
    d1z = (d1 == '0);
    d2z = (d2 == '0);
    d3z = (d3 == '0);
    d4z = (d4 == '0);
    // A proper crossing needs strictly opposite signs on both pairs.
    cross_a = !d1z && !d2z && (d1[OW-1] != d2[OW-1]);
    cross_b = !d3z && !d4z && (d3[OW-1] != d4[OW-1]);
    touch = (cross_a && cross_b)
         || (d1z && in_box(cur_r.sx, cur_r.sy, cur_r.ex, cur_r.ey, new_seg.sx, new_seg.sy))
         || (d2z && in_box(cur_r.sx, cur_r.sy, cur_r.ex, cur_r.ey, new_seg.ex, new_seg.ey))
         || (d3z && in_box(new_seg.sx, new_seg.sy, new_seg.ex, new_seg.ey, cur_r.sx, cur_r.sy))
         || (d4z && in_box(new_seg.sx, new_seg.sy, new_seg.ex, new_seg.ey, cur_r.ex, cur_r.ey));
  end

endmodule
